[hw/rtl/dq_pkg.sv]
// Shared types, constants and pointer helpers for the double-ended queue.
// No dependencies; imported by every other module of the block.
`default_nettype none

package dq_pkg;

  localparam int DEPTH     = 1024;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int WORD_W    = 32;
  localparam int CNT_OUT_W = 11;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam word_t NONE_WORD = '1;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } cmd_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [CNT_OUT_W-1:0] cnt_out(input cnt_t c);
    logic [CNT_W+CNT_OUT_W-1:0] w;
    w = {{CNT_OUT_W{1'b0}}, c};
    return w[CNT_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dq_ctrl.sv]
// Controller for the double-ended queue: accept / result-load sequencing.
// Depends on dq_pkg for the command struct.
`default_nettype none

module dq_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output dq_pkg::cmd_t     cmd
);
  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_tvalid;
    cmd.commit = (state_r == S_READ) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_READ;
          if (out_tready) out_valid_r <= 1'b0;
        end
        S_READ: begin
          if (cmd.commit) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dq_datapath.sv]
// Datapath for the double-ended queue: word memory, pointers, cached end words
// and the result register. Depends on dq_pkg.
`default_nettype none

module dq_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dq_pkg::cmd_t                  cmd,
  input  wire dq_pkg::action_t               in_action,
  input  wire dq_pkg::word_t                 in_push_value,
  output dq_pkg::word_t                      out_popped_value,
  output logic [1:0]                         out_status,
  output logic [dq_pkg::CNT_OUT_W-1:0]       out_entry_count,
  output logic                               out_is_empty,
  output dq_pkg::word_t                      out_front_value,
  output dq_pkg::word_t                      out_back_value
);
  import dq_pkg::*;

  word_t mem [DEPTH];

  ptr_t    head_r, head_nxt;
  ptr_t    tail_r, tail_nxt;
  cnt_t    count_r, count_nxt;
  word_t   front_r, front_nxt, front_new;
  word_t   back_r, back_nxt, back_new;
  word_t   popped_r, popped_nxt;
  status_t status_r, status_nxt;
  logic    pend_front_r, pend_front_nxt;
  logic    pend_back_r, pend_back_nxt;
  word_t   rd_data_r;

  logic  full, empty;
  logic  mem_we, mem_re;
  ptr_t  mem_waddr, mem_raddr;

  word_t                  res_popped_r, res_front_r, res_back_r;
  status_t                res_status_r;
  logic [CNT_OUT_W-1:0]   res_count_r;
  logic                   res_empty_r;

  always_comb begin
    full           = (count_r == CNT_W'(DEPTH));
    empty          = (count_r == '0);
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    popped_nxt     = NONE_WORD;
    status_nxt     = ST_OK;
    pend_front_nxt = 1'b0;
    pend_back_nxt  = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_re         = 1'b0;
    mem_raddr      = head_r;
    unique case (in_action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          head_nxt  = ptr_dec(head_r);
          mem_we    = 1'b1;
          mem_waddr = head_nxt;
          count_nxt = count_r + 1'b1;
          front_nxt = in_push_value;
          if (empty) back_nxt = in_push_value;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          tail_nxt  = ptr_inc(tail_r);
          mem_we    = 1'b1;
          mem_waddr = tail_r;
          count_nxt = count_r + 1'b1;
          back_nxt  = in_push_value;
          if (empty) front_nxt = in_push_value;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt       = ptr_inc(head_r);
          popped_nxt     = front_r;
          mem_re         = 1'b1;
          mem_raddr      = head_nxt;
          count_nxt      = count_r - 1'b1;
          pend_front_nxt = 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          tail_nxt      = ptr_dec(tail_r);
          popped_nxt    = back_r;
          mem_re        = 1'b1;
          mem_raddr     = ptr_dec(tail_nxt);
          count_nxt     = count_r - 1'b1;
          pend_back_nxt = 1'b1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  assign front_new = pend_front_r ? rd_data_r : front_r;
  assign back_new  = pend_back_r  ? rd_data_r : back_r;

  always_ff @(posedge clk) begin
    if (mem_we && cmd.accept) mem[mem_waddr] <= in_push_value;
    if (mem_re && cmd.accept) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.accept) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      front_r      <= front_nxt;
      back_r       <= back_nxt;
      popped_r     <= popped_nxt;
      status_r     <= status_nxt;
      pend_front_r <= pend_front_nxt;
      pend_back_r  <= pend_back_nxt;
    end else if (cmd.commit) begin
      front_r <= front_new;
      back_r  <= back_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_popped_r <= popped_r;
      res_status_r <= status_r;
      res_count_r  <= cnt_out(count_r);
      res_empty_r  <= (count_r == '0);
      res_front_r  <= (count_r == '0) ? NONE_WORD : front_new;
      res_back_r   <= (count_r == '0) ? NONE_WORD : back_new;
    end
  end

  assign out_popped_value = res_popped_r;
  assign out_status       = res_status_r;
  assign out_entry_count  = res_count_r;
  assign out_is_empty     = res_empty_r;
  assign out_front_value  = res_front_r;
  assign out_back_value   = res_back_r;

  logic [CNT_W:0] span_sum, span_wrap;

  always_comb begin
    span_sum  = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
    span_wrap = (span_sum >= (CNT_W+1)'(DEPTH)) ? span_sum - (CNT_W+1)'(DEPTH) : span_sum;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == span_wrap[PTR_W-1:0])
    else $error("tail pointer out of step with head plus occupancy");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && full && (in_action == ACT_PUSH_FRONT || in_action == ACT_PUSH_BACK)
    |=> count_r == $past(count_r) && head_r == $past(head_r))
    else $error("push into full queue changed state");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && empty && (in_action == ACT_POP_FRONT || in_action == ACT_POP_BACK)
    |=> status_r == ST_EMPTY && count_r == '0)
    else $error("pop on empty queue not flagged");

endmodule

`default_nettype wire

[hw/rtl/double_ended_queue.sv]
// Top level of the double-ended queue: stream ports, controller and datapath.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
//
//   channel | dir | tdata / tuser contents
//   in      | in  | tdata: push_value; tuser: action
//   out     | out | tdata: popped, count, empty, front, back; tuser: status
//
// For each item, the accept state (S_IDLE) updates pointers and writes or
// reads the word memory; S_READ then loads the result register from the
// registered memory read. A new item is accepted the cycle after that load,
// even while the result still waits on out_tready. If the result register is
// still full, the item holds in S_READ until it drains.
// Synchronous reset empties the queue; the memory is not cleared.
`default_nettype none

module double_ended_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [31:0]   in_tdata,   // [31:0] push_value
  input  wire logic [1:0]    in_tuser,   // [1:0] action
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [111:0]       out_tdata,  // [31:0] popped_value, [42:32] entry_count,
                                         // [43] is_empty, [75:44] front_value,
                                         // [107:76] back_value, [111:108] zero
  output logic [1:0]         out_tuser   // [1:0] status
);
  import dq_pkg::*;

  cmd_t                  cmd;
  action_t               action;
  word_t                 push_value;
  word_t                 popped_value, front_value, back_value;
  logic [1:0]            status;
  logic [CNT_OUT_W-1:0]  entry_count;
  logic                  is_empty;

  assign action     = action_t'(in_tuser);
  assign push_value = in_tdata[WORD_W-1:0];

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dq_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (action),
    .in_push_value    (push_value),
    .out_popped_value (popped_value),
    .out_status       (status),
    .out_entry_count  (entry_count),
    .out_is_empty     (is_empty),
    .out_front_value  (front_value),
    .out_back_value   (back_value)
  );

  assign out_tdata = {4'b0000, back_value, front_value, is_empty, entry_count, popped_value};
  assign out_tuser = status;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the double_ended_queue stream block.
// Depends on dq_pkg and the RTL; predicts each result with a queue of words
// and checks every output transfer field by field.
`timescale 1ns / 1ps

module tb;
  import dq_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_PRINTS = 50;

  typedef struct {
    word_t                 popped;
    status_t               status;
    logic [CNT_OUT_W-1:0]  count;
    logic                  empty;
    word_t                 front;
    word_t                 back;
  } deq_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;   // [31:0] push_value
  logic [1:0]   in_tuser = '0;   // [1:0] action
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [111:0] out_tdata;       // [31:0] popped, [42:32] count, [43] empty,
                                 // [75:44] front, [107:76] back
  logic [1:0]   out_tuser;       // [1:0] status

  word_t       held_words[$];
  deq_result_t pending_results[$];
  deq_result_t want;
  bit          idle_on = 1'b1;
  int          n_fail = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_full_drops = 0;
  int          n_empty_pops = 0;
  int          max_fill = 0;
  int          idle_cycles = 0;

  double_ended_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (n_fail < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, field, got, exp_val);
    n_fail++;
  endtask

  // Apply one accepted transfer to the word queue and record the result it owes.
  task automatic deque_step_predict(input action_t act, input word_t val);
    deq_result_t r;
    r.popped = NONE_WORD;
    r.status = ST_OK;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (held_words.size() >= DEPTH) begin
          r.status = ST_FULL;
          n_full_drops++;
        end else if (act == ACT_PUSH_FRONT) begin
          held_words.insert(0, val);
        end else begin
          held_words.insert(held_words.size(), val);
        end
      end
      default: begin
        if (held_words.size() == 0) begin
          r.status = ST_EMPTY;
          n_empty_pops++;
        end else if (act == ACT_POP_FRONT) begin
          r.popped = held_words[0];
          held_words.delete(0);
        end else begin
          r.popped = held_words[$];
          held_words.delete(held_words.size() - 1);
        end
      end
    endcase
    r.count = CNT_OUT_W'(held_words.size());
    r.empty = (held_words.size() == 0);
    r.front = r.empty ? NONE_WORD : held_words[0];
    r.back  = r.empty ? NONE_WORD : held_words[$];
    if (held_words.size() > max_fill) max_fill = held_words.size();
    pending_results.insert(pending_results.size(), r);
  endtask

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_item(input action_t act, input word_t val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    deque_step_predict(act, val);
    n_sent++;
  endtask

  task automatic test_empty_pops();
    send_item(ACT_POP_FRONT, word_t'($urandom));
    send_item(ACT_POP_BACK, word_t'($urandom));
  endtask

  task automatic test_edge_words();
    send_item(ACT_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_item(ACT_PUSH_BACK, 32'sh8000_0000);
    send_item(ACT_PUSH_FRONT, 32'sh0000_0000);
    send_item(ACT_PUSH_BACK, 32'shFFFF_FFFF);
    send_item(ACT_PUSH_BACK, 32'shAAAA_AAAA);
    send_item(ACT_PUSH_FRONT, 32'sh5555_5555);
    send_item(ACT_POP_BACK, word_t'($urandom));
    send_item(ACT_POP_FRONT, word_t'($urandom));
    send_item(ACT_POP_FRONT, word_t'($urandom));
    send_item(ACT_POP_BACK, word_t'($urandom));
    send_item(ACT_POP_FRONT, word_t'($urandom));
    send_item(ACT_POP_BACK, word_t'($urandom));
    send_item(ACT_POP_BACK, word_t'($urandom));
  endtask

  task automatic test_single_word();
    send_item(ACT_PUSH_BACK, word_t'($urandom));
    send_item(ACT_POP_FRONT, word_t'($urandom));
    send_item(ACT_PUSH_FRONT, word_t'($urandom));
    send_item(ACT_POP_BACK, word_t'($urandom));
    send_item(ACT_PUSH_FRONT, word_t'($urandom));
    send_item(ACT_POP_FRONT, word_t'($urandom));
  endtask

  // Mostly pushes until full, then keep pushing so some get dropped.
  task automatic test_fill_to_full();
    int drops0;
    drops0 = n_full_drops;
    while (held_words.size() < DEPTH || n_full_drops - drops0 < 16) begin
      if ($urandom_range(0, 39) != 0)
        send_item(action_t'($urandom_range(0, 1)), word_t'($urandom));
      else
        send_item(action_t'($urandom_range(2, 3)), word_t'($urandom));
    end
  endtask

  task automatic test_drain_to_empty();
    int pops0;
    pops0 = n_empty_pops;
    while (held_words.size() != 0 || n_empty_pops - pops0 < 6) begin
      if ($urandom_range(0, 39) != 0)
        send_item(action_t'($urandom_range(2, 3)), word_t'($urandom));
      else
        send_item(action_t'($urandom_range(0, 1)), word_t'($urandom));
    end
  endtask

  task automatic test_random_mix(input int n_items);
    repeat (n_items) send_item(action_t'($urandom_range(0, 3)), word_t'($urandom));
  endtask

  task automatic test_back_to_back(input int n_items);
    idle_on = 1'b0;
    repeat (n_items) send_item(action_t'($urandom_range(0, 3)), word_t'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], '0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        n_checked++;
        if (out_tdata[31:0] !== want.popped)
          report_mismatch("popped_value", out_tdata[31:0], want.popped);
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[42:32] !== want.count)
          report_mismatch("entry_count", 32'(out_tdata[42:32]), 32'(want.count));
        if (out_tdata[43] !== want.empty)
          report_mismatch("is_empty", 32'(out_tdata[43]), 32'(want.empty));
        if (out_tdata[75:44] !== want.front)
          report_mismatch("front_value", out_tdata[75:44], want.front);
        if (out_tdata[107:76] !== want.back)
          report_mismatch("back_value", out_tdata[107:76], want.back);
      end
    end
  end

  // Receiver stalls in bursts while idling is enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pops();
    test_edge_words();
    test_single_word();
    test_fill_to_full();
    test_drain_to_empty();
    test_random_mix(100);
    test_back_to_back(150);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d transfers in, %0d results checked, peak fill %0d of %0d words.",
             n_sent, n_checked, max_fill, DEPTH);
    $display("Pushes dropped on a full queue: %0d; pops on an empty queue: %0d.",
             n_full_drops, n_empty_pops);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
